@@ src/clcd_pkg.sv @@
// Shared types, constants and microcode layout for the character LCD controller.
`default_nettype none
package clcd_pkg;

    // Operation codes carried in the func field
    localparam logic [2:0] FuncCommand = 3'd0;
    localparam logic [2:0] FuncData    = 3'd1;
    localparam logic [2:0] FuncClear   = 3'd2;
    localparam logic [2:0] FuncCursor  = 3'd3;
    localparam logic [2:0] FuncInit    = 3'd4;

    // Timing constants in milliseconds
    localparam logic [5:0] PowerUpMs  = 6'd50;
    localparam logic [5:0] StrobeMs   = 6'd1;
    localparam logic [5:0] CmdSlowMs  = 6'd2;

    // Command bytes that need the long execution time
    localparam logic [7:0] CmdClear = 8'h01;
    localparam logic [7:0] CmdHome  = 8'h02;

    // Microcode address width and program entry points
    localparam int unsigned UpcW = 4;
    localparam logic [UpcW-1:0] EntByte  = 4'd0;
    localparam logic [UpcW-1:0] EntClear = 4'd2;
    localparam logic [UpcW-1:0] EntInit  = 4'd4;

    // Kind of step: one nibble (three pin states) or one idle state
    typedef enum logic {
        UK_NIB  = 1'b0,
        UK_WAIT = 1'b1
    } t_ukind;

    // Where the nibble of a step comes from
    typedef enum logic [1:0] {
        US_CONST = 2'd0,
        US_HI    = 2'd1,
        US_LO    = 2'd2
    } t_usrc;

    // One control word of the sequencer program
    typedef struct packed {
        t_ukind          kind;
        t_usrc           src;
        logic [3:0]      nib;    // constant nibble for US_CONST
        logic [2:0]      extra;  // extra ms held on the third pin state
        logic            cmdx;   // add the slow-command delay if the byte asks for it
        logic            done;   // final step of the operation
        logic [UpcW-1:0] nxt;    // following step
    } t_uword;

    // Sequencer state, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage
`default_nettype wire

@@ src/clcd_in_if.sv @@
// Input channel: one operation word with its handshake.
`default_nettype none
interface clcd_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] col;

    modport source (output valid, output func, output byte_value, output row, output col,
                    input ready);
    modport sink   (input valid, input func, input byte_value, input row, input col,
                    output ready);
endinterface
`default_nettype wire

@@ src/clcd_out_if.sv @@
// Output channel: one pin-state word with its handshake.
`default_nettype none
interface clcd_out_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       enable;
    logic [3:0] data_nibble;
    logic [5:0] hold_ms;
    logic       last;

    modport source (output valid, output reg_select, output enable, output data_nibble,
                    output hold_ms, output last, input ready);
    modport sink   (input valid, input reg_select, input enable, input data_nibble,
                    input hold_ms, input last, output ready);
endinterface
`default_nettype wire

@@ src/clcd_urom.sv @@
// Microcode ROM: the step programs for byte, clear and init operations.
`default_nettype none
module clcd_urom (
    input  wire logic [clcd_pkg::UpcW-1:0] i_addr,
    output clcd_pkg::t_uword               o_uword
);

    function automatic clcd_pkg::t_uword uw(
        input clcd_pkg::t_ukind          kind,
        input clcd_pkg::t_usrc           src,
        input logic [3:0]                nib,
        input logic [2:0]                extra,
        input logic                      cmdx,
        input logic                      done,
        input logic [clcd_pkg::UpcW-1:0] nxt
    );
        clcd_pkg::t_uword w;
        w.kind  = kind;
        w.src   = src;
        w.nib   = nib;
        w.extra = extra;
        w.cmdx  = cmdx;
        w.done  = done;
        w.nxt   = nxt;
        return w;
    endfunction

    always_comb begin
        case (i_addr)
            // byte program: high nibble, then low nibble with slow-command check
            4'd0:    o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_HI, 4'h0, 3'd0, 1'b0, 1'b0, 4'd1);
            4'd1:    o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_LO, 4'h0, 3'd0, 1'b1, 1'b1, 4'd0);
            // clear: 0x01 with 4 ms extra on the low nibble; the slow-command delay is not added
            4'd2:    o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h0, 3'd0, 1'b0, 1'b0,
                                  4'd3);
            4'd3:    o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h1, 3'd4, 1'b0, 1'b1,
                                  4'd0);
            // init: power-up wait, wake-up nibbles, function/display/entry, then clear
            4'd4:    o_uword = uw(clcd_pkg::UK_WAIT, clcd_pkg::US_CONST, 4'h0, 3'd0, 1'b0, 1'b0,
                                  4'd5);
            4'd5:    o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h3, 3'd5, 1'b0, 1'b0,
                                  4'd6);
            4'd6:    o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h3, 3'd5, 1'b0, 1'b0,
                                  4'd7);
            4'd7:    o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h3, 3'd1, 1'b0, 1'b0,
                                  4'd8);
            4'd8:    o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h2, 3'd1, 1'b0, 1'b0,
                                  4'd9);
            4'd9:    o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h2, 3'd0, 1'b0, 1'b0,
                                  4'd10);
            4'd10:   o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h8, 3'd0, 1'b0, 1'b0,
                                  4'd11);
            4'd11:   o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h0, 3'd0, 1'b0, 1'b0,
                                  4'd12);
            4'd12:   o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'hC, 3'd0, 1'b0, 1'b0,
                                  4'd13);
            4'd13:   o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h0, 3'd0, 1'b0, 1'b0,
                                  4'd14);
            4'd14:   o_uword = uw(clcd_pkg::UK_NIB, clcd_pkg::US_CONST, 4'h6, 3'd0, 1'b0, 1'b0,
                                  clcd_pkg::EntClear);
            default: o_uword = uw(clcd_pkg::UK_WAIT, clcd_pkg::US_CONST, 4'h0, 3'd0, 1'b0, 1'b1,
                                  4'd0);
        endcase
    end

endmodule
`default_nettype wire

@@ src/char_lcd_4bit_interface_core.sv @@
// Top level: microcoded sequencer turning LCD operations into timed pin states.
// Start: an accepted operation moves the sequencer to run, and its first pin state is then registered.
// Throughput: one pin state per cycle while the sink is ready; 6 states for command, data,
//   cursor and clear, 37 for init; a new operation is taken only once the sequencer is idle.
//   The pace is set by the single step counter walking the microcode ROM.
// Reset: synchronous, active low; returns to idle and drops the output valid.
`default_nettype none
module char_lcd_4bit_interface_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    clcd_in_if.sink        i_cmd,
    clcd_out_if.source     o_pin
);

    // Control state
    clcd_pkg::t_state             r_state, n_state;
    logic [clcd_pkg::UpcW-1:0]    r_pc, n_pc;
    logic [1:0]                   r_phase, n_phase;   // pin state within a nibble: 0, 1, 2
    logic                         r_ovalid, n_ovalid;

    // Datapath registers (no reset needed)
    logic [7:0]                   r_byte, n_byte;
    logic                         r_rs, n_rs;
    logic                         r_o_rs, n_o_rs;
    logic                         r_o_en, n_o_en;
    logic [3:0]                   r_o_nib, n_o_nib;
    logic [5:0]                   r_o_hold, n_o_hold;
    logic                         r_o_last, n_o_last;

    clcd_pkg::t_uword             uword;
    logic                         in_take;
    logic                         out_free;
    logic                         slow_cmd;
    logic                         step_end;
    logic [3:0]                   nib;

    clcd_urom u_urom (
        .i_addr  (r_pc),
        .o_uword (uword)
    );

    // Accept a new operation only when the sequencer is idle
    assign i_cmd.ready = (r_state == clcd_pkg::S_IDLE);
    assign in_take     = i_cmd.valid && i_cmd.ready;

    // Output register may load when empty or being drained this cycle
    assign out_free = !r_ovalid || o_pin.ready;

    // Clear and home commands need the long execution delay; data never does
    assign slow_cmd = uword.cmdx && !r_rs && (r_byte == clcd_pkg::CmdClear ||
                                              r_byte == clcd_pkg::CmdHome);

    // A step ends after its single idle state or after the third pin state of a nibble
    assign step_end = (uword.kind == clcd_pkg::UK_WAIT) || (r_phase == 2'd2);

    always_comb begin
        case (uword.src)
            clcd_pkg::US_HI: nib = r_byte[7:4];
            clcd_pkg::US_LO: nib = r_byte[3:0];
            default:         nib = uword.nib;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_phase  = r_phase;
        n_ovalid = r_ovalid && !o_pin.ready;
        n_byte   = r_byte;
        n_rs     = r_rs;
        n_o_rs   = r_o_rs;
        n_o_en   = r_o_en;
        n_o_nib  = r_o_nib;
        n_o_hold = r_o_hold;
        n_o_last = r_o_last;

        case (r_state)
            clcd_pkg::S_IDLE: begin
                // Decode the operation into a byte, a register select and an entry point
                n_phase = 2'd0;
                if (in_take) begin
                    n_rs   = 1'b0;
                    n_byte = i_cmd.byte_value;
                    case (i_cmd.func)
                        clcd_pkg::FuncCommand: begin
                            n_pc    = clcd_pkg::EntByte;
                            n_state = clcd_pkg::S_RUN;
                        end
                        clcd_pkg::FuncData: begin
                            n_rs    = 1'b1;
                            n_pc    = clcd_pkg::EntByte;
                            n_state = clcd_pkg::S_RUN;
                        end
                        clcd_pkg::FuncClear: begin
                            n_pc    = clcd_pkg::EntClear;
                            n_state = clcd_pkg::S_RUN;
                        end
                        clcd_pkg::FuncCursor: begin
                            // 0x80 | (row base + col); col < 64 so this never carries
                            n_byte  = {1'b1, i_cmd.row, i_cmd.col};
                            n_pc    = clcd_pkg::EntByte;
                            n_state = clcd_pkg::S_RUN;
                        end
                        clcd_pkg::FuncInit: begin
                            n_pc    = clcd_pkg::EntInit;
                            n_state = clcd_pkg::S_RUN;
                        end
                        default: begin
                            // undefined codes produce no pin states
                            n_state = clcd_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            clcd_pkg::S_RUN: begin
                if (out_free) begin
                    // Build the next pin state from the current control word
                    n_ovalid = 1'b1;
                    n_o_rs   = r_rs;
                    n_o_last = uword.done && step_end;
                    if (uword.kind == clcd_pkg::UK_WAIT) begin
                        n_o_rs   = 1'b0;
                        n_o_en   = 1'b0;
                        n_o_nib  = 4'h0;
                        n_o_hold = clcd_pkg::PowerUpMs;
                    end else begin
                        n_o_en  = (r_phase == 2'd1);
                        n_o_nib = nib;
                        if (r_phase == 2'd2) begin
                            n_o_hold = clcd_pkg::StrobeMs + {3'b000, uword.extra}
                                     + (slow_cmd ? clcd_pkg::CmdSlowMs : 6'd0);
                        end else begin
                            n_o_hold = clcd_pkg::StrobeMs;
                        end
                    end
                    // Advance the phase, then the step, then drop back to idle
                    if (step_end) begin
                        n_phase = 2'd0;
                        if (uword.done) begin
                            n_state = clcd_pkg::S_IDLE;
                        end else begin
                            n_pc = uword.nxt;
                        end
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            default: begin
                n_state = clcd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= clcd_pkg::S_IDLE;
            r_pc     <= clcd_pkg::EntByte;
            r_phase  <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_rs     <= n_rs;
        r_o_rs   <= n_o_rs;
        r_o_en   <= n_o_en;
        r_o_nib  <= n_o_nib;
        r_o_hold <= n_o_hold;
        r_o_last <= n_o_last;
    end

    assign o_pin.valid       = r_ovalid;
    assign o_pin.reg_select  = r_o_rs;
    assign o_pin.enable      = r_o_en;
    assign o_pin.data_nibble = r_o_nib;
    assign o_pin.hold_ms     = r_o_hold;
    assign o_pin.last        = r_o_last;

endmodule
`default_nettype wire
